### rtl/fcull_pkg.sv
// fcull_pkg: shared types and constants for the frustum cull test.
// Used by fcull_cell and frustum_cull_test; no dependencies.
package fcull_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PlaneW  = 64;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 15;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned DistW   = 34;
  localparam int unsigned FracSh  = 14;

  localparam logic [1:0] KindPoint  = 2'd0;
  localparam logic [1:0] KindSphere = 2'd1;
  localparam logic [1:0] KindBox    = 2'd2;

  localparam logic [1:0] VerdictInside    = 2'd0;
  localparam logic [1:0] VerdictIntersect = 2'd1;
  localparam logic [1:0] VerdictOutside   = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [CoordW-1:0]  pos_x;
    logic signed [CoordW-1:0]  pos_y;
    logic signed [CoordW-1:0]  pos_z;
    logic [RadiusW-1:0]        radius;
    logic signed [CoordW-1:0]  max_x;
    logic signed [CoordW-1:0]  max_y;
    logic signed [CoordW-1:0]  max_z;
  } item_t;

  typedef struct packed {
    logic outside;
    logic touch;
  } flags_t;

endpackage

### rtl/fcull_cell.sv
// fcull_cell: one plane of the culling chain, two stages (products, then sum/compare).
// Holds its own plane register. Depends on fcull_pkg.
module fcull_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcull_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fcull_pkg::PlaneW-1:0]      cfg_data_i,
  input  logic                              valid_i,
  input  fcull_pkg::item_t                  item_i,
  input  fcull_pkg::flags_t                 flags_i,
  output logic                              valid_o,
  output fcull_pkg::item_t                  item_o,
  output fcull_pkg::flags_t                 flags_o
);

  localparam logic [fcull_pkg::CfgIdxW-1:0] MyIdx = fcull_pkg::CfgIdxW'(CellIdx);

  logic [fcull_pkg::PlaneW-1:0] plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == MyIdx)) begin
      plane_q <= cfg_data_i;
    end
  end

  logic signed [fcull_pkg::CoordW-1:0] nx, ny, nz, dofs;
  assign nx   = plane_q[15:0];
  assign ny   = plane_q[31:16];
  assign nz   = plane_q[47:32];
  assign dofs = plane_q[63:48];

  // stage 1: vertex select and products
  logic                                 is_box;
  logic signed [fcull_pkg::CoordW-1:0]  vx, vy, vz, wx, wy, wz;
  logic signed [fcull_pkg::ProdW-1:0]   pv_d [3];
  logic signed [fcull_pkg::ProdW-1:0]   pw_d [3];

  always_comb begin
    is_box = (item_i.kind == fcull_pkg::KindBox);
    vx = (is_box && !nx[15] && (nx != '0)) ? item_i.max_x : item_i.pos_x;
    vy = (is_box && !ny[15] && (ny != '0)) ? item_i.max_y : item_i.pos_y;
    vz = (is_box && !nz[15] && (nz != '0)) ? item_i.max_z : item_i.pos_z;
    wx = (is_box && nx[15]) ? item_i.max_x : item_i.pos_x;
    wy = (is_box && ny[15]) ? item_i.max_y : item_i.pos_y;
    wz = (is_box && nz[15]) ? item_i.max_z : item_i.pos_z;
    pv_d[0] = nx * vx;
    pv_d[1] = ny * vy;
    pv_d[2] = nz * vz;
    pw_d[0] = nx * wx;
    pw_d[1] = ny * wy;
    pw_d[2] = nz * wz;
  end

  logic                               s1_valid_q;
  fcull_pkg::item_t                   s1_item_q;
  fcull_pkg::flags_t                  s1_flags_q;
  logic signed [fcull_pkg::ProdW-1:0] pv_q [3];
  logic signed [fcull_pkg::ProdW-1:0] pw_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q  <= item_i;
    s1_flags_q <= flags_i;
    pv_q       <= pv_d;
    pw_q       <= pw_d;
  end

  // stage 2: distances and classification
  logic signed [fcull_pkg::DistW-1:0] dterm, rad, dv, dw;
  fcull_pkg::flags_t                  flags_d;

  always_comb begin
    dterm = {{4{dofs[15]}}, dofs, {fcull_pkg::FracSh{1'b0}}};
    rad   = {5'b0, s1_item_q.radius, {fcull_pkg::FracSh{1'b0}}};
    dv = {{2{pv_q[0][31]}}, pv_q[0]} + {{2{pv_q[1][31]}}, pv_q[1]}
       + {{2{pv_q[2][31]}}, pv_q[2]} + dterm;
    dw = {{2{pw_q[0][31]}}, pw_q[0]} + {{2{pw_q[1][31]}}, pw_q[1]}
       + {{2{pw_q[2][31]}}, pw_q[2]} + dterm;
    flags_d = s1_flags_q;
    case (s1_item_q.kind)
      fcull_pkg::KindSphere: begin
        if (dv < -rad) begin
          flags_d.outside = 1'b1;
        end else if (dv < rad) begin
          flags_d.touch = 1'b1;
        end
      end
      fcull_pkg::KindBox: begin
        if (dv[fcull_pkg::DistW-1]) begin
          flags_d.outside = 1'b1;
        end else if (dw[fcull_pkg::DistW-1]) begin
          flags_d.touch = 1'b1;
        end
      end
      default: begin
        if (dv[fcull_pkg::DistW-1]) begin
          flags_d.outside = 1'b1;
        end
      end
    endcase
  end

  logic              s2_valid_q;
  fcull_pkg::item_t  s2_item_q;
  fcull_pkg::flags_t s2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_item_q  <= s1_item_q;
    s2_flags_q <= flags_d;
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_item_q;
  assign flags_o = s2_flags_q;

endmodule

### rtl/frustum_cull_test.sv
// frustum_cull_test: six-plane frustum culling of points, spheres and boxes.
// Path from start to done_o: two stages per plane cell, then one output register.
// Throughput: one request per cycle, set by the cell chain.
// busy is never raised; results cannot be stalled.
// Reset clears all plane registers to zero and the valid bits of the chain.
// Depends on fcull_pkg and fcull_cell.
module frustum_cull_test #(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fcull_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fcull_pkg::PlaneW-1:0]       cfg_data_i,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         kind_i,
  input  logic signed [fcull_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [fcull_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [fcull_pkg::CoordW-1:0] pos_z_i,
  input  logic [fcull_pkg::RadiusW-1:0]      radius_i,
  input  logic signed [fcull_pkg::CoordW-1:0] max_x_i,
  input  logic signed [fcull_pkg::CoordW-1:0] max_y_i,
  input  logic signed [fcull_pkg::CoordW-1:0] max_z_i,
  output logic                               done_o,
  output logic [1:0]                         verdict_o
);

  localparam int unsigned Lat = 2 * PLANE_COUNT + 1;

  logic              valid_c [PLANE_COUNT+1];
  fcull_pkg::item_t  item_c  [PLANE_COUNT+1];
  fcull_pkg::flags_t flags_c [PLANE_COUNT+1];

  assign busy       = 1'b0;
  assign valid_c[0] = start && !busy;
  assign item_c[0]  = '{kind: kind_i, pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                        radius: radius_i, max_x: max_x_i, max_y: max_y_i, max_z: max_z_i};
  assign flags_c[0] = '{outside: 1'b0, touch: 1'b0};

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    fcull_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_we_i  (cfg_we_i),
      .cfg_idx_i (cfg_idx_i),
      .cfg_data_i(cfg_data_i),
      .valid_i   (valid_c[g]),
      .item_i    (item_c[g]),
      .flags_i   (flags_c[g]),
      .valid_o   (valid_c[g+1]),
      .item_o    (item_c[g+1]),
      .flags_o   (flags_c[g+1])
    );
  end

  logic       done_q;
  logic [1:0] verdict_q, verdict_d;

  always_comb begin
    if (flags_c[PLANE_COUNT].outside) begin
      verdict_d = fcull_pkg::VerdictOutside;
    end else if (flags_c[PLANE_COUNT].touch) begin
      verdict_d = fcull_pkg::VerdictIntersect;
    end else begin
      verdict_d = fcull_pkg::VerdictInside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c[PLANE_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign done_o    = done_q;
  assign verdict_o = verdict_q;

  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("request did not complete at the expected latency");

  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without a matching request");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (verdict_o == fcull_pkg::VerdictInside ||
                verdict_o == fcull_pkg::VerdictIntersect ||
                verdict_o == fcull_pkg::VerdictOutside))
    else $error("verdict code out of range");

endmodule

### bench/frustum_cull_test_tb.sv
`timescale 1ns / 100ps
// frustum_cull_test_tb: self-checking bench for the six-plane frustum cull block.
// Predicts each verdict from its own copy of the plane registers; depends on fcull_pkg.
module frustum_cull_test_tb;

  localparam int unsigned PlaneCount = 6;
  localparam int unsigned QuietLimit = 2000;
  localparam logic [1:0]  KindPoint  = fcull_pkg::KindPoint;
  localparam logic [1:0]  KindSphere = fcull_pkg::KindSphere;
  localparam logic [1:0]  KindBox    = fcull_pkg::KindBox;
  localparam logic [1:0]  KindUnused = 2'd3;

  typedef enum logic [2:0] {
    RegTop, RegBottom, RegLeft, RegRight, RegNear, RegFar, RegSpare6, RegSpare7
  } plane_reg_e;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [fcull_pkg::CfgIdxW-1:0]        cfg_idx_i;
  logic [fcull_pkg::PlaneW-1:0]         cfg_data_i;
  logic                                 start;
  logic                                 busy;
  logic [1:0]                           kind_i;
  logic signed [fcull_pkg::CoordW-1:0]  pos_x_i, pos_y_i, pos_z_i;
  logic [fcull_pkg::RadiusW-1:0]        radius_i;
  logic signed [fcull_pkg::CoordW-1:0]  max_x_i, max_y_i, max_z_i;
  logic                                 done_o;
  logic [1:0]                           verdict_o;

  logic [fcull_pkg::PlaneW-1:0] plane_regs [PlaneCount];
  logic [1:0]        verdict_q [$];
  logic [1:0]        want_verdict;
  int                idle_pct;
  int                fail_count;
  int                quiet_cycles;

  frustum_cull_test #(.PLANE_COUNT(PlaneCount)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .radius_i   (radius_i),
    .max_x_i    (max_x_i),
    .max_y_i    (max_y_i),
    .max_z_i    (max_z_i),
    .done_o     (done_o),
    .verdict_o  (verdict_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // signed distance n.P + d in Q.14
  function automatic longint plane_dist(input int unsigned idx, input longint x,
                                        input longint y, input longint z);
    longint nx, ny, nz, d;
    nx = $signed(plane_regs[idx][15:0]);
    ny = $signed(plane_regs[idx][31:16]);
    nz = $signed(plane_regs[idx][47:32]);
    d  = $signed(plane_regs[idx][63:48]);
    return nx * x + ny * y + nz * z + d * 64'sd16384;
  endfunction

  function automatic logic [1:0] classify_primitive(input fcull_pkg::item_t it);
    longint px, py, pz, qx, qy, qz, r, dval;
    longint nx, ny, nz;
    bit     outside, touch;
    outside = 1'b0;
    touch   = 1'b0;
    px = $signed(it.pos_x);
    py = $signed(it.pos_y);
    pz = $signed(it.pos_z);
    qx = $signed(it.max_x);
    qy = $signed(it.max_y);
    qz = $signed(it.max_z);
    r  = longint'(it.radius) * 64'sd16384;
    for (int unsigned i = 0; i < PlaneCount; i++) begin
      if (it.kind == KindSphere) begin
        dval = plane_dist(i, px, py, pz);
        if (dval < -r) outside = 1'b1;
        else if (dval < r) touch = 1'b1;
      end else if (it.kind == KindBox) begin
        nx = $signed(plane_regs[i][15:0]);
        ny = $signed(plane_regs[i][31:16]);
        nz = $signed(plane_regs[i][47:32]);
        if (plane_dist(i, nx > 0 ? qx : px, ny > 0 ? qy : py, nz > 0 ? qz : pz) < 0)
          outside = 1'b1;
        else if (plane_dist(i, nx < 0 ? qx : px, ny < 0 ? qy : py, nz < 0 ? qz : pz) < 0)
          touch = 1'b1;
      end else begin
        // unused kind falls back to point
        if (plane_dist(i, px, py, pz) < 0) outside = 1'b1;
      end
    end
    if (outside) return fcull_pkg::VerdictOutside;
    if (touch) return fcull_pkg::VerdictIntersect;
    return fcull_pkg::VerdictInside;
  endfunction

  function automatic logic [63:0] plane_word(input shortint nx, input shortint ny,
                                             input shortint nz, input shortint d);
    return {d, nz, ny, nx};
  endfunction

  // axis-aligned cube of half size 1600
  function automatic logic [63:0] cube_plane(input int unsigned idx);
    case (idx)
      RegTop:    return plane_word(16'sd0, -16'sd16384, 16'sd0, 16'sd1600);
      RegBottom: return plane_word(16'sd0, 16'sd16384, 16'sd0, 16'sd1600);
      RegLeft:   return plane_word(16'sd16384, 16'sd0, 16'sd0, 16'sd1600);
      RegRight:  return plane_word(-16'sd16384, 16'sd0, 16'sd0, 16'sd1600);
      RegNear:   return plane_word(16'sd0, 16'sd0, 16'sd16384, 16'sd1600);
      default:   return plane_word(16'sd0, 16'sd0, -16'sd16384, 16'sd1600);
    endcase
  endfunction

  function automatic logic [63:0] rand_plane(input int set_sel, input int unsigned idx);
    case (set_sel)
      0: return cube_plane(idx);
      1: return {1'b0, 15'($urandom), 48'({$urandom, $urandom})};
      2: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 2))
          0: return cube_plane(idx);
          1: return '0;
          default: return {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 6400)) - 3200);
  endfunction

  function automatic fcull_pkg::item_t rand_item();
    fcull_pkg::item_t it;
    int               sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) it.kind = KindUnused;
    else if (sel % 3 == 0) it.kind = KindPoint;
    else if (sel % 3 == 1) it.kind = KindSphere;
    else it.kind = KindBox;
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    it.pos_z = rand_coord();
    if ($urandom_range(0, 3) == 0) it.radius = 15'($urandom);
    else it.radius = 15'($urandom_range(0, 1600));
    if ($urandom_range(0, 9) == 0) begin
      it.max_x = rand_coord();
      it.max_y = rand_coord();
      it.max_z = rand_coord();
    end else begin
      it.max_x = it.pos_x + 16'($urandom_range(0, 800));
      it.max_y = it.pos_y + 16'($urandom_range(0, 800));
      it.max_z = it.pos_z + 16'($urandom_range(0, 800));
    end
    return it;
  endfunction

  function automatic fcull_pkg::item_t make_item(input logic [1:0] kind, input shortint x,
                                                 input shortint y, input shortint z,
                                                 input int unsigned rad, input shortint mx,
                                                 input shortint my, input shortint mz);
    fcull_pkg::item_t it;
    it.kind   = kind;
    it.pos_x  = x;
    it.pos_y  = y;
    it.pos_z  = z;
    it.radius = 15'(rad);
    it.max_x  = mx;
    it.max_y  = my;
    it.max_z  = mz;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic write_plane(input plane_reg_e idx, input logic [63:0] word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= word;
    @(posedge clk_i);
    if (int'(idx) < PlaneCount) plane_regs[idx] = word;
  endtask

  task automatic release_cfg();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_plane_set(input int set_sel);
    for (int unsigned i = 0; i < PlaneCount; i++)
      write_plane(plane_reg_e'(i), rand_plane(set_sel, i));
    release_cfg();
  endtask

  task automatic issue_request(input fcull_pkg::item_t it);
    int gap;
    start    <= 1'b1;
    kind_i   <= it.kind;
    pos_x_i  <= it.pos_x;
    pos_y_i  <= it.pos_y;
    pos_z_i  <= it.pos_z;
    radius_i <= it.radius;
    max_x_i  <= it.max_x;
    max_y_i  <= it.max_y;
    max_z_i  <= it.max_z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    verdict_q.push_back(classify_primitive(it));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_zero_planes();
    issue_request(make_item(KindPoint, -16'sd32768, 16'sd32767, 16'sd0, 0, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd5, 16'sd5, 16'sd5, 0, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd5, 16'sd5, 16'sd5, 1, 0, 0, 0));
    issue_request(make_item(KindBox, -16'sd10, -16'sd10, -16'sd10, 0, 16'sd10, 16'sd10,
                            16'sd10));
    issue_request(make_item(KindUnused, 16'sd0, 16'sd0, 16'sd0, 32767, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_cube_directed();
    load_plane_set(0);
    issue_request(make_item(KindPoint, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0));
    issue_request(make_item(KindPoint, 16'sd1601, 16'sd0, 16'sd0, 0, 0, 0, 0));
    issue_request(make_item(KindPoint, 16'sd1600, -16'sd1600, 16'sd1600, 0, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd0, 16'sd0, 16'sd0, 1600, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd1650, 16'sd0, 16'sd0, 1600, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd0, 16'sd3300, 16'sd0, 1600, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd0, 16'sd0, 16'sd0, 32767, 0, 0, 0));
    issue_request(make_item(KindBox, -16'sd100, -16'sd100, -16'sd100, 0, 16'sd100,
                            16'sd100, 16'sd100));
    issue_request(make_item(KindBox, 16'sd1500, 16'sd0, 16'sd0, 0, 16'sd1700, 16'sd10,
                            16'sd10));
    issue_request(make_item(KindBox, 16'sd0, 16'sd0, 16'sd1700, 0, 16'sd10, 16'sd10,
                            16'sd1800));
    // inverted corners are used as given
    issue_request(make_item(KindBox, 16'sd100, 16'sd100, 16'sd100, 0, -16'sd100,
                            -16'sd100, -16'sd100));
    issue_request(make_item(KindBox, -16'sd32768, -16'sd32768, -16'sd32768, 0,
                            16'sd32767, 16'sd32767, 16'sd32767));
    issue_request(make_item(KindUnused, -16'sd32768, 16'sd32767, -16'sd32768, 5, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_extreme_planes();
    write_plane(RegTop,    64'h7FFF_7FFF_7FFF_7FFF);
    write_plane(RegBottom, 64'h8000_8000_8000_8000);
    write_plane(RegLeft,   64'hFFFF_FFFF_FFFF_FFFF);
    write_plane(RegRight,  64'h8000_7FFF_8000_7FFF);
    write_plane(RegNear,   64'h0000_0000_0000_0000);
    write_plane(RegFar,    64'h7FFF_8000_7FFF_8000);
    release_cfg();
    issue_request(make_item(KindPoint, 16'sd32767, 16'sd32767, 16'sd32767, 0, 0, 0, 0));
    issue_request(make_item(KindSphere, -16'sd32768, -16'sd32768, -16'sd32768, 32767,
                            0, 0, 0));
    issue_request(make_item(KindBox, -16'sd32768, -16'sd32768, -16'sd32768, 0,
                            16'sd32767, 16'sd32767, 16'sd32767));
    issue_request(make_item(KindSphere, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_spare_index();
    load_plane_set(0);
    write_plane(RegSpare6, 64'hFFFF_0000_0000_0000);
    write_plane(RegSpare7, 64'h8000_8000_8000_8000);
    release_cfg();
    issue_request(make_item(KindPoint, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0));
    issue_request(make_item(KindSphere, 16'sd0, 16'sd0, 16'sd0, 100, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random_stream();
    for (int set_sel = 0; set_sel < 4; set_sel++) begin
      for (int phase = 0; phase < 3; phase++) begin
        wait_drained();
        if (phase == 0) load_plane_set(set_sel);
        idle_pct = (phase == 0) ? 0 : (phase == 1) ? 62 : 19;
        for (int n = 0; n < 150; n++) begin
          issue_request(rand_item());
          if ($urandom_range(0, 199) == 0) wait_drained();
        end
      end
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, verdict=%0d",
                                  verdict_o));
      end else begin
        want_verdict = verdict_q.pop_front();
        if (verdict_o !== want_verdict)
          report_mismatch($sformatf("verdict got %0d want %0d", verdict_o, want_verdict));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("frustum_cull_test test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fail_count   = 0;
    quiet_cycles = 0;
    idle_pct     = 0;
    for (int unsigned i = 0; i < PlaneCount; i++) plane_regs[i] = '0;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    start      <= 1'b0;
    kind_i     <= KindPoint;
    pos_x_i    <= '0;
    pos_y_i    <= '0;
    pos_z_i    <= '0;
    radius_i   <= '0;
    max_x_i    <= '0;
    max_y_i    <= '0;
    max_z_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_planes();
    test_cube_directed();
    test_extreme_planes();
    test_spare_index();
    test_random_stream();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    if (fail_count == 0) begin
      $display("frustum_cull_test test passed");
    end else begin
      $display("frustum_cull_test test failed");
    end
    $finish;
  end

endmodule
